@@ rtl/pls_pkg.sv @@
package pls_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int IDX_W = 6;
	localparam int COORD_W = 32;

	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic final_point;
	} pls_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] point_index;
		logic signed [COORD_W-1:0] sorted_x;
		logic signed [COORD_W-1:0] sorted_y;
		logic run_end;
		logic dropped;
	} pls_out_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} pls_entry_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_PASS,
		S_RUN,
		S_HEAD,
		S_MERGE,
		S_EMIT_RD,
		S_EMIT_LD
	} pls_state_t;

	typedef struct packed {
		logic load;
		logic sort_init;
		logic run_init;
		logic head;
		logic merge;
		logic emit_init;
		logic emit_rd;
		logic emit_ld;
	} pls_cmd_t;

	typedef struct packed {
		logic pass_done;
		logic run_last_elem;
		logic pass_last_run;
		logic out_busy;
		logic emit_last;
	} pls_stat_t;

endpackage

@@ rtl/pls_chan_if.sv @@
interface pls_chan_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/point_lexicographic_sorter_core.sv @@
// Sorts a set of points by x, then y, both signed 16.16, keeping arrival order among equal
// points. Points are taken one item per cycle while the core is loading; the item with
// final_point set closes the set, and points that arrive while MAX_POINTS are already held
// are discarded and reported through dropped on every result of that run. The sort is a
// bottom-up merge between two on-chip buffers: each of the ceil(log2 n) passes has a start
// step, then for each merged run pair two setup steps followed by a merge step that writes
// the points of the pair in turn. The results then leave one at a time from a registered
// output stage, the next being read only once the previous one has been taken. A new set
// may start loading while the last result still waits to be taken.
module point_lexicographic_sorter_core #(
	parameter int MAX_POINTS = pls_pkg::MAX_POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	pls_chan_if.sink points,
	pls_chan_if.source sorted
);

	pls_pkg::pls_cmd_t cmd;
	pls_pkg::pls_stat_t stat;
	pls_pkg::pls_in_t in_data;
	pls_pkg::pls_out_t out_data;
	logic out_valid;
	logic in_ready;

	assign in_data = points.data;
	assign points.ready = in_ready;
	assign sorted.valid = out_valid;
	assign sorted.data = out_data;

	pls_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(points.valid),
		.in_final(in_data.final_point),
		.stat(stat),
		.in_ready(in_ready),
		.cmd(cmd)
	);

	pls_datapath #(
		.MAX_POINTS(MAX_POINTS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.in_data(in_data),
		.out_ready(sorted.ready),
		.out_valid(out_valid),
		.out_data(out_data)
	);

endmodule

@@ rtl/pls_ctrl.sv @@
module pls_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_final,
	input pls_pkg::pls_stat_t stat,
	output logic in_ready,
	output pls_pkg::pls_cmd_t cmd
);

	pls_pkg::pls_state_t state_q;
	pls_pkg::pls_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pls_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pls_pkg::S_LOAD: begin
				if (in_valid && in_final) begin
					state_d = pls_pkg::S_PASS;
				end
			end
			pls_pkg::S_PASS: begin
				state_d = stat.pass_done ? pls_pkg::S_EMIT_RD : pls_pkg::S_RUN;
			end
			pls_pkg::S_RUN: begin
				state_d = pls_pkg::S_HEAD;
			end
			pls_pkg::S_HEAD: begin
				state_d = pls_pkg::S_MERGE;
			end
			pls_pkg::S_MERGE: begin
				if (stat.run_last_elem) begin
					state_d = stat.pass_last_run ? pls_pkg::S_PASS : pls_pkg::S_RUN;
				end
			end
			pls_pkg::S_EMIT_RD: begin
				if (!stat.out_busy) begin
					state_d = pls_pkg::S_EMIT_LD;
				end
			end
			pls_pkg::S_EMIT_LD: begin
				state_d = stat.emit_last ? pls_pkg::S_LOAD : pls_pkg::S_EMIT_RD;
			end
			default: begin
				state_d = pls_pkg::S_LOAD;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			pls_pkg::S_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.sort_init = in_valid && in_final;
			end
			pls_pkg::S_PASS: begin
				cmd.emit_init = stat.pass_done;
			end
			pls_pkg::S_RUN: begin
				cmd.run_init = 1'b1;
			end
			pls_pkg::S_HEAD: begin
				cmd.head = 1'b1;
			end
			pls_pkg::S_MERGE: begin
				cmd.merge = 1'b1;
			end
			pls_pkg::S_EMIT_RD: begin
				cmd.emit_rd = !stat.out_busy;
			end
			pls_pkg::S_EMIT_LD: begin
				cmd.emit_ld = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/pls_datapath.sv @@
module pls_datapath #(
	parameter int MAX_POINTS = pls_pkg::MAX_POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input pls_pkg::pls_cmd_t cmd,
	output pls_pkg::pls_stat_t stat,
	input pls_pkg::pls_in_t in_data,
	input logic out_ready,
	output logic out_valid,
	output pls_pkg::pls_out_t out_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int PW = AW + 2;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

	// Two ping-pong buffers of {arrival index, x, y}; each pass merges one into the other.
	pls_pkg::pls_entry_t buf0 [MAX_POINTS];
	pls_pkg::pls_entry_t buf1 [MAX_POINTS];
	pls_pkg::pls_entry_t rdata0_q;
	pls_pkg::pls_entry_t rdata1_q;

	logic [CW-1:0] count_q;
	logic ovf_q;
	logic src_q;
	logic [PW-1:0] width_q;
	logic [PW-1:0] lo_q;
	logic [PW-1:0] mid_q;
	logic [PW-1:0] hi_q;
	logic [PW-1:0] i_q;
	logic [PW-1:0] j_q;
	logic [PW-1:0] k_q;
	logic pend_q;
	logic fill_i_q;
	pls_pkg::pls_entry_t head_i_q;
	pls_pkg::pls_entry_t head_j_q;
	logic out_valid_q;
	pls_pkg::pls_out_t out_q;

	logic [PW-1:0] n_p;
	logic [PW-1:0] w2;
	logic [PW-1:0] mid_sum;
	logic [PW-1:0] run_end_pos;
	logic [PW-1:0] mid_c;
	logic [PW-1:0] hi_c;
	logic [PW-1:0] i_nx;
	logic [PW-1:0] j_nx;
	logic [PW-1:0] k_nx;
	pls_pkg::pls_entry_t rdata;
	pls_pkg::pls_entry_t head_i;
	pls_pkg::pls_entry_t head_j;
	logic j_first;
	logic take_i;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic wr0;
	logic wr1;
	logic [AW-1:0] wr_addr;
	pls_pkg::pls_entry_t wr_data;
	logic can_store;

	assign n_p = PW'(count_q);
	assign w2 = width_q << 1;
	assign mid_sum = lo_q + width_q;
	assign run_end_pos = lo_q + w2;
	assign mid_c = (mid_sum > n_p) ? n_p : mid_sum;
	assign hi_c = (run_end_pos > n_p) ? n_p : run_end_pos;
	assign i_nx = i_q + PW'(1);
	assign j_nx = j_q + PW'(1);
	assign k_nx = k_q + PW'(1);
	assign can_store = count_q < FULL;

	// A head whose refill read was issued last cycle is taken straight from the read data.
	assign rdata = src_q ? rdata1_q : rdata0_q;
	assign head_i = (pend_q && fill_i_q) ? rdata : head_i_q;
	assign head_j = (pend_q && !fill_i_q) ? rdata : head_j_q;

	assign j_first = (head_j.x < head_i.x) || ((head_j.x == head_i.x) && (head_j.y < head_i.y));
	assign take_i = (i_q < mid_q) && ((j_q >= hi_q) || !j_first);

	assign stat.pass_done = width_q >= n_p;
	assign stat.run_last_elem = k_nx == hi_q;
	assign stat.pass_last_run = run_end_pos >= n_p;
	assign stat.out_busy = out_valid_q;
	assign stat.emit_last = k_nx == n_p;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		if (cmd.run_init) begin
			rd_en = 1'b1;
			rd_addr = lo_q[AW-1:0];
		end else if (cmd.head) begin
			rd_en = j_q < hi_q;
			rd_addr = j_q[AW-1:0];
		end else if (cmd.merge) begin
			if (take_i) begin
				rd_en = i_nx < mid_q;
				rd_addr = i_nx[AW-1:0];
			end else begin
				rd_en = j_nx < hi_q;
				rd_addr = j_nx[AW-1:0];
			end
		end else if (cmd.emit_rd) begin
			rd_en = 1'b1;
			rd_addr = k_q[AW-1:0];
		end
	end

	always_comb begin
		wr0 = (cmd.load && can_store) || (cmd.merge && src_q);
		wr1 = cmd.merge && !src_q;
		if (cmd.load) begin
			wr_addr = count_q[AW-1:0];
			wr_data.idx = pls_pkg::IDX_W'(count_q);
			wr_data.x = in_data.px;
			wr_data.y = in_data.py;
		end else begin
			wr_addr = k_q[AW-1:0];
			wr_data = take_i ? head_i : head_j;
		end
	end

	always_ff @(posedge clk) begin
		if (wr0) begin
			buf0[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata0_q <= buf0[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr1) begin
			buf1[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata1_q <= buf1[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			src_q <= 1'b0;
			width_q <= '0;
			lo_q <= '0;
			mid_q <= '0;
			hi_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			pend_q <= 1'b0;
			fill_i_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (can_store) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.sort_init) begin
				width_q <= PW'(1);
				src_q <= 1'b0;
				lo_q <= '0;
			end
			if (cmd.run_init) begin
				mid_q <= mid_c;
				hi_q <= hi_c;
				i_q <= lo_q;
				j_q <= mid_c;
				k_q <= lo_q;
				pend_q <= 1'b0;
			end
			if (cmd.head) begin
				pend_q <= 1'b1;
				fill_i_q <= 1'b0;
			end
			if (cmd.merge) begin
				pend_q <= rd_en;
				fill_i_q <= take_i;
				k_q <= k_nx;
				if (take_i) begin
					i_q <= i_nx;
				end else begin
					j_q <= j_nx;
				end
				if (stat.run_last_elem) begin
					if (stat.pass_last_run) begin
						width_q <= w2;
						src_q <= !src_q;
						lo_q <= '0;
					end else begin
						lo_q <= run_end_pos;
					end
				end
			end
			if (cmd.emit_init) begin
				k_q <= '0;
			end
			if (cmd.emit_ld) begin
				k_q <= k_nx;
				if (stat.emit_last) begin
					count_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			if (cmd.emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.head) begin
			head_i_q <= rdata;
		end
		if (cmd.merge) begin
			head_i_q <= head_i;
			head_j_q <= head_j;
		end
		if (cmd.emit_ld) begin
			out_q.point_index <= rdata.idx;
			out_q.sorted_x <= rdata.x;
			out_q.sorted_y <= rdata.y;
			out_q.run_end <= stat.emit_last;
			out_q.dropped <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ dv/point_lexicographic_sorter_core_test.sv @@
module point_lexicographic_sorter_core_test;

	localparam int MAXP = pls_pkg::MAX_POINTS_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;

	pls_chan_if #(.payload_t(pls_pkg::pls_in_t)) points_ch ();
	pls_chan_if #(.payload_t(pls_pkg::pls_out_t)) sorted_ch ();

	point_lexicographic_sorter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points_ch),
		.sorted(sorted_ch)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	pls_pkg::pls_in_t pend_q[$];
	pls_pkg::pls_out_t sorted_q[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	logic signed [pls_pkg::COORD_W-1:0] held_x [MAXP];
	logic signed [pls_pkg::COORD_W-1:0] held_y [MAXP];
	int held_n = 0;
	bit held_over = 1'b0;

	int error_cnt = 0;
	int points_taken = 0;
	int results_checked = 0;
	int sets_closed = 0;
	int overflow_sets = 0;
	int quiet_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_ch.valid <= 1'b0;
			points_ch.data <= '0;
		end else if (!points_ch.valid || points_ch.ready) begin
			if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				points_ch.data <= pend_q.pop_front();
				points_ch.valid <= 1'b1;
			end else begin
				points_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_ch.ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (hold_req) begin
				hold_left <= HOLD_CYCLES;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
			sorted_ch.ready <= !hold_req && hold_left <= 1 &&
				$urandom_range(99) >= recv_stall_pct;
		end
	end

	function automatic bit comes_first(input logic [pls_pkg::IDX_W-1:0] a,
		input logic [pls_pkg::IDX_W-1:0] b);
		if (held_x[a] != held_x[b]) begin
			return held_x[a] < held_x[b];
		end
		return held_y[a] < held_y[b];
	endfunction

	function automatic void predict_sorted_run(input pls_pkg::pls_in_t pt);
		logic [pls_pkg::IDX_W-1:0] order [MAXP];
		logic [pls_pkg::IDX_W-1:0] key;
		int j;
		pls_pkg::pls_out_t res;
		if (held_n < MAXP) begin
			held_x[held_n] = pt.px;
			held_y[held_n] = pt.py;
			held_n++;
		end else begin
			held_over = 1'b1;
		end
		if (pt.final_point) begin
			for (int i = 0; i < held_n; i++) begin
				order[i] = i[pls_pkg::IDX_W-1:0];
			end
			// Insertion sort keeps equal points in arrival order.
			for (int i = 1; i < held_n; i++) begin
				key = order[i];
				j = i;
				while (j > 0 && comes_first(key, order[j-1])) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = key;
			end
			for (int k = 0; k < held_n; k++) begin
				res.point_index = order[k];
				res.sorted_x = held_x[order[k]];
				res.sorted_y = held_y[order[k]];
				res.run_end = (k == held_n - 1);
				res.dropped = held_over;
				sorted_q.push_back(res);
			end
			sets_closed++;
			if (held_over) begin
				overflow_sets++;
			end
			held_n = 0;
			held_over = 1'b0;
		end
	endfunction

	always @(posedge clk) begin
		pls_pkg::pls_out_t want;
		pls_pkg::pls_out_t got;
		bit in_fire;
		bit out_fire;
		if (arst_n) begin
			in_fire = points_ch.valid && points_ch.ready;
			out_fire = sorted_ch.valid && sorted_ch.ready;
			if (in_fire) begin
				points_taken++;
				predict_sorted_run(points_ch.data);
			end
			if (out_fire) begin
				got = sorted_ch.data;
				if (sorted_q.size() == 0) begin
					if (error_cnt < 10) begin
						$display("unexpected sorted item: idx %0d x %h y %h end %b drop %b",
							got.point_index, got.sorted_x, got.sorted_y, got.run_end,
							got.dropped);
					end
					error_cnt++;
				end else begin
					want = sorted_q.pop_front();
					results_checked++;
					if (got.point_index !== want.point_index || got.sorted_x !== want.sorted_x ||
						got.sorted_y !== want.sorted_y || got.run_end !== want.run_end ||
						got.dropped !== want.dropped) begin
						if (error_cnt < 10) begin
							$display("mismatch: expected idx %0d x %h y %h end %b drop %b",
								want.point_index, want.sorted_x, want.sorted_y, want.run_end,
								want.dropped);
							$display("          actual   idx %0d x %h y %h end %b drop %b",
								got.point_index, got.sorted_x, got.sorted_y, got.run_end,
								got.dropped);
						end
						error_cnt++;
					end
				end
			end
			if (in_fire || out_fire) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("point_lexicographic_sorter_core regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic add_point(input logic [31:0] x, input logic [31:0] y, input bit last);
		pls_pkg::pls_in_t pt;
		pt.px = x;
		pt.py = y;
		pt.final_point = last;
		pend_q.push_back(pt);
	endtask

	function automatic logic [31:0] pick_coord();
		logic [31:0] pool [6];
		pool[0] = 32'h0000_0000;
		pool[1] = 32'hffff_ffff;
		pool[2] = 32'h7fff_ffff;
		pool[3] = 32'h8000_0000;
		pool[4] = 32'h0001_0000;
		pool[5] = 32'hffff_0000;
		if ($urandom_range(9) < 4) begin
			return pool[$urandom_range(5)];
		end
		return $urandom;
	endfunction

	task automatic add_random_set(input int n);
		@(negedge clk);
		for (int i = 0; i < n; i++) begin
			add_point(pick_coord(), pick_coord(), i == n - 1);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pend_q.size() != 0 || points_ch.valid || sorted_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		int sent;
		int n;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_idling(0, 0);
		@(negedge clk);
		add_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
		add_point(32'h7fff_ffff, 32'h8000_0000, 1'b1);
		add_point(32'h0000_0005, 32'h0000_0001, 1'b0);
		add_point(32'hffff_fffb, 32'h0000_0001, 1'b1);
		add_point(32'h0000_0000, 32'h0000_0000, 1'b0);
		add_point(32'hffff_ffff, 32'h0000_0005, 1'b0);
		add_point(32'h0000_0000, 32'h0000_0000, 1'b0);
		add_point(32'h0000_0000, 32'hffff_ffff, 1'b0);
		add_point(32'h7fff_ffff, 32'h0000_0000, 1'b0);
		add_point(32'h8000_0000, 32'h8000_0000, 1'b0);
		add_point(32'hffff_ffff, 32'h0000_0005, 1'b0);
		add_point(32'h0001_0000, 32'h7fff_ffff, 1'b0);
		add_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
		wait_drained();

		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: set_idling(0, 0);
				1: set_idling(79, 0);
				2: set_idling(0, 79);
				default: set_idling(22, 22);
			endcase
			sent = 0;
			while (sent < 17) begin
				n = ($urandom_range(4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
				add_random_set(n);
				sent += n;
			end
			if (mode == 2) begin
				// Two points past capacity, the closing one among them.
				add_random_set(MAXP + 2);
			end
			wait_drained();
		end

		// Hold the result side off while two sets are offered, so the core backs up.
		set_idling(0, 0);
		hold_req = 1'b1;
		@(negedge clk);
		hold_req = 1'b0;
		add_point(pick_coord(), pick_coord(), 1'b0);
		add_random_set(5);
		add_random_set(6);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d points in %0d sets (%0d with overflow) under four idling mixes",
			points_taken, sets_closed, overflow_sets);
		$display("checked %0d sorted items, %0d failures", results_checked, error_cnt);
		if (error_cnt == 0 && sorted_q.size() == 0) begin
			$display("point_lexicographic_sorter_core regression: pass");
		end else begin
			$display("point_lexicographic_sorter_core regression: fail");
		end
		$finish;
	end

endmodule
